// ----- rtl/core/pdc_pkg.sv -----
// Shared constants and types of the particle domain classifier.
// No dependencies; every other file imports this package.
package pdc_pkg;

  localparam int COORD_BITS_DEF     = 20;
  localparam int GRID_AXIS_BITS_DEF = 4;
  localparam int FIFO_DEPTH         = 2;

  // configuration register indexes
  localparam logic [2:0] REG_BOX_MIN       = 3'd0;
  localparam logic [2:0] REG_BOX_MAX       = 3'd1;
  localparam logic [2:0] REG_LOCAL_MIN     = 3'd2;
  localparam logic [2:0] REG_LOCAL_MAX     = 3'd3;
  localparam logic [2:0] REG_GRID_SHAPE    = 3'd4;
  localparam logic [2:0] REG_OWN_COORDS    = 3'd5;
  localparam logic [2:0] REG_PERIODIC_MASK = 3'd6;
  localparam logic [2:0] REG_HALO_WIDTH    = 3'd7;

  typedef struct packed {
    logic in_local;
    logic in_wide;
  } pdc_flags_t;

endpackage

// ----- rtl/core/pdc_front.sv -----
// Front end: request capture and per-axis offset/sign preparation.
// Depends on pdc_pkg; feeds pdc_fifo.
module pdc_front #(
  parameter int COORD_BITS = pdc_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [COORD_BITS+1:0]           pos_x,
  input  logic signed [COORD_BITS+1:0]           pos_y,
  input  logic signed [COORD_BITS+1:0]           pos_z,
  input  logic                                   wrap_first,
  input  logic [3*COORD_BITS-1:0]                box_min,
  input  logic                                   fifo_full,
  output logic                                   push,
  output logic [3*(2*(COORD_BITS+2)+1):0]        push_data
);
  import pdc_pkg::*;

  localparam int PB = COORD_BITS + 2;
  localparam int AW = 2 * PB + 1;
  localparam int IW = 3 * AW + 1;

  logic          valid_r, valid_nxt;
  logic [IW-1:0] data_r, data_nxt;
  logic          accept;
  logic signed [PB-1:0] pos [3];
  logic signed [PB:0]   diff [3];
  logic [PB:0]          negd [3];

  assign busy   = valid_r && fifo_full;
  assign accept = start && !busy;
  assign push   = valid_r && !fifo_full;
  assign push_data = data_r;

  assign pos[0] = pos_x;
  assign pos[1] = pos_y;
  assign pos[2] = pos_z;

  always_comb begin
    data_nxt = data_r;
    valid_nxt = valid_r;
    if (push) valid_nxt = 1'b0;
    if (accept) begin
      valid_nxt = 1'b1;
      for (int a = 0; a < 3; a++) begin
        diff[a] = $signed({pos[a][PB-1], pos[a]}) - $signed({2'b00, box_min[a*COORD_BITS +: COORD_BITS]});
        negd[a] = -diff[a];
        data_nxt[a*AW +: PB]       = pos[a];
        data_nxt[a*AW + PB +: PB]  = diff[a][PB] ? negd[a][PB-1:0] : diff[a][PB-1:0];
        data_nxt[a*AW + 2*PB]      = diff[a][PB];
      end
      data_nxt[IW-1] = wrap_first;
    end else begin
      for (int a = 0; a < 3; a++) begin
        diff[a] = '0;
        negd[a] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
    data_r <= data_nxt;
  end

endmodule

// ----- rtl/core/pdc_fifo.sv -----
// Short request queue between front and back ends.
// Depends on pdc_pkg (depth).
module pdc_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);
  import pdc_pkg::*;

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [WIDTH-1:0] mem [FIFO_DEPTH];
  logic [PW-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(FIFO_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(FIFO_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop_valid) begin
      rd_nxt = (rd_r == PW'(FIFO_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop_valid)      cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop_valid) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem[wr_r] <= push_data;
  end

endmodule

// ----- rtl/core/pdc_axis.sv -----
// One axis of the back end: pipelined floor-mod wrap, cell quotient, box tests.
// Depends on pdc_pkg; instantiated three times by pdc_back.
module pdc_axis #(
  parameter int COORD_BITS     = pdc_pkg::COORD_BITS_DEF,
  parameter int GRID_AXIS_BITS = pdc_pkg::GRID_AXIS_BITS_DEF
) (
  input  logic                          clk,
  input  logic signed [COORD_BITS+1:0]  in_p,
  input  logic [COORD_BITS+1:0]         in_mag,
  input  logic                          in_neg,
  input  logic                          in_wf,
  input  logic [COORD_BITS-1:0]         gmin,
  input  logic [COORD_BITS-1:0]         gmax,
  input  logic [COORD_BITS-1:0]         lmin,
  input  logic [COORD_BITS-1:0]         lmax,
  input  logic [GRID_AXIS_BITS:0]       gfield,
  input  logic [GRID_AXIS_BITS-1:0]     own,
  input  logic                          per,
  input  logic [COORD_BITS-1:0]         halo,
  output logic signed [COORD_BITS+1:0]  out_w,
  output logic [GRID_AXIS_BITS-1:0]     out_cell,
  output pdc_pkg::pdc_flags_t           out_flags,
  output logic [GRID_AXIS_BITS:0]       out_g
);
  import pdc_pkg::*;

  localparam int PB = COORD_BITS + 2;
  localparam int QB = GRID_AXIS_BITS + 1;
  localparam int NW = PB + GRID_AXIS_BITS;
  localparam int XW = NW + 1;
  localparam int HW = COORD_BITS + 3;

  logic                  len_ok;
  logic [COORD_BITS-1:0] len;
  logic [QB-1:0]         g, gm1;
  localparam logic [QB-1:0] GSAT = {1'b1, {GRID_AXIS_BITS{1'b0}}};

  assign len_ok = gmax > gmin;
  assign len    = gmax - gmin;
  assign g      = (gfield == '0) ? QB'(1) : (gfield > GSAT) ? GSAT : gfield;
  assign gm1    = g - 1'b1;
  assign out_g  = g;

  // remainder stages, one magnitude bit each
  logic [COORD_BITS-1:0] rem_r [PB];
  logic [PB-1:0]         mag_r [PB];
  logic                  neg_r [PB];
  logic                  wf_r  [PB];
  logic signed [PB-1:0]  p_r   [PB];
  logic [COORD_BITS-1:0] rem_in [PB];
  logic [PB-1:0]         mag_in [PB];
  logic                  neg_in [PB];
  logic                  wf_in  [PB];
  logic signed [PB-1:0]  p_in   [PB];
  logic [COORD_BITS-1:0] rem_nxt [PB];
  logic [COORD_BITS:0]   t [PB];

  always_comb begin
    for (int k = 0; k < PB; k++) begin
      if (k == 0) begin
        rem_in[k] = '0;
        mag_in[k] = in_mag;
        neg_in[k] = in_neg;
        wf_in[k]  = in_wf;
        p_in[k]   = in_p;
      end else begin
        rem_in[k] = rem_r[k-1];
        mag_in[k] = mag_r[k-1];
        neg_in[k] = neg_r[k-1];
        wf_in[k]  = wf_r[k-1];
        p_in[k]   = p_r[k-1];
      end
      t[k] = {rem_in[k], mag_in[k][PB-1-k]};
      rem_nxt[k] = (t[k] >= {1'b0, len}) ? COORD_BITS'(t[k] - {1'b0, len})
                                         : t[k][COORD_BITS-1:0];
    end
  end

  // stage A: wrapped and classified position
  logic [COORD_BITS-1:0] rem_f, r_f;
  logic signed [PB-1:0]  w_a_nxt, q_a_nxt, w_a_r, q_a_r;

  always_comb begin
    rem_f   = rem_r[PB-1];
    r_f     = (neg_r[PB-1] && rem_f != '0) ? len - rem_f : rem_f;
    w_a_nxt = (per && len_ok) ? $signed({2'b00, gmin + r_f}) : p_r[PB-1];
    q_a_nxt = wf_r[PB-1] ? w_a_nxt : p_r[PB-1];
  end

  // stage B: box tests, scaled offset
  logic signed [PB:0]   n_b;
  logic signed [HW-1:0] qh, lmin_e, lmax_e, halo_e, lo, hi;
  logic                 has_prev, has_next, pos_b_nxt;
  logic [NW-1:0]        nn_b_nxt;
  pdc_flags_t           fl_b_nxt;

  always_comb begin
    n_b       = $signed({q_a_r[PB-1], q_a_r}) - $signed({3'b000, gmin});
    pos_b_nxt = len_ok && ($signed({q_a_r[PB-1], q_a_r}) > $signed({3'b000, gmin}));
    nn_b_nxt  = NW'(n_b[PB-2:0]) * NW'(g);
    qh        = {{(HW-PB){q_a_r[PB-1]}}, q_a_r};
    lmin_e    = $signed({3'b000, lmin});
    lmax_e    = $signed({3'b000, lmax});
    halo_e    = $signed({3'b000, halo});
    has_prev  = per || (own != '0);
    has_next  = per || (({1'b0, own} + QB'(1)) < g);
    lo        = has_prev ? lmin_e - halo_e : lmin_e;
    hi        = has_next ? lmax_e + halo_e : lmax_e;
    fl_b_nxt.in_local = (qh >= lmin_e) && (qh < lmax_e);
    fl_b_nxt.in_wide  = (qh >= lo) && (qh < hi);
  end

  logic signed [PB-1:0] w_b_r;
  logic [NW-1:0]        nn_b_r;
  logic                 pos_b_r;
  pdc_flags_t           fl_b_r;

  // stage S: quotient overflow check
  logic [XW-1:0] len_top;
  logic          sat_nxt;
  assign len_top = XW'(len) << QB;
  assign sat_nxt = {1'b0, nn_b_r} >= len_top;

  logic signed [PB-1:0] w_s_r;
  logic [NW-1:0]        nn_s_r;
  logic                 pos_s_r, sat_s_r;
  pdc_flags_t           fl_s_r;

  // quotient digit stages, most significant first
  logic [NW-1:0]        nn_d_r [QB];
  logic [QB-1:0]        c_d_r  [QB];
  logic signed [PB-1:0] w_d_r  [QB];
  logic                 pos_d_r [QB];
  logic                 sat_d_r [QB];
  pdc_flags_t           fl_d_r  [QB];
  logic [NW-1:0]        nn_in [QB];
  logic [QB-1:0]        c_in  [QB];
  logic [NW-1:0]        nn_nxt [QB];
  logic [QB-1:0]        c_nxt  [QB];
  logic [XW-1:0]        dv [QB];

  always_comb begin
    for (int j = 0; j < QB; j++) begin
      nn_in[j] = (j == 0) ? nn_s_r : nn_d_r[(j == 0) ? 0 : j-1];
      c_in[j]  = (j == 0) ? '0     : c_d_r[(j == 0) ? 0 : j-1];
      dv[j]    = XW'(len) << (QB - 1 - j);
      nn_nxt[j] = nn_in[j];
      c_nxt[j]  = c_in[j];
      if ({1'b0, nn_in[j]} >= dv[j]) begin
        nn_nxt[j] = nn_in[j] - dv[j][NW-1:0];
        c_nxt[j][QB-1-j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < PB; k++) begin
      rem_r[k] <= rem_nxt[k];
      mag_r[k] <= mag_in[k];
      neg_r[k] <= neg_in[k];
      wf_r[k]  <= wf_in[k];
      p_r[k]   <= p_in[k];
    end
    w_a_r   <= w_a_nxt;
    q_a_r   <= q_a_nxt;
    w_b_r   <= w_a_r;
    nn_b_r  <= nn_b_nxt;
    pos_b_r <= pos_b_nxt;
    fl_b_r  <= fl_b_nxt;
    w_s_r   <= w_b_r;
    nn_s_r  <= nn_b_r;
    pos_s_r <= pos_b_r;
    sat_s_r <= sat_nxt;
    fl_s_r  <= fl_b_r;
    for (int j = 0; j < QB; j++) begin
      nn_d_r[j] <= nn_nxt[j];
      c_d_r[j]  <= c_nxt[j];
      w_d_r[j]  <= (j == 0) ? w_s_r   : w_d_r[(j == 0) ? 0 : j-1];
      pos_d_r[j] <= (j == 0) ? pos_s_r : pos_d_r[(j == 0) ? 0 : j-1];
      sat_d_r[j] <= (j == 0) ? sat_s_r : sat_d_r[(j == 0) ? 0 : j-1];
      fl_d_r[j]  <= (j == 0) ? fl_s_r  : fl_d_r[(j == 0) ? 0 : j-1];
    end
  end

  // cell zero unless above the box minimum; otherwise clamp to the last cell
  always_comb begin
    if (!pos_d_r[QB-1])
      out_cell = '0;
    else if (sat_d_r[QB-1] || c_d_r[QB-1] > gm1)
      out_cell = gm1[GRID_AXIS_BITS-1:0];
    else
      out_cell = c_d_r[QB-1][GRID_AXIS_BITS-1:0];
  end

  assign out_w     = w_d_r[QB-1];
  assign out_flags = fl_d_r[QB-1];

endmodule

// ----- rtl/core/pdc_back.sv -----
// Back end: three axis pipelines, rank linearisation and result registers.
// Depends on pdc_pkg and pdc_axis; fed by pdc_fifo.
module pdc_back #(
  parameter int COORD_BITS     = pdc_pkg::COORD_BITS_DEF,
  parameter int GRID_AXIS_BITS = pdc_pkg::GRID_AXIS_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [3*(2*(COORD_BITS+2)+1):0]     in_data,
  input  logic [3*COORD_BITS-1:0]             box_min,
  input  logic [3*COORD_BITS-1:0]             box_max,
  input  logic [3*COORD_BITS-1:0]             local_min,
  input  logic [3*COORD_BITS-1:0]             local_max,
  input  logic [3*(GRID_AXIS_BITS+1)-1:0]     grid_shape,
  input  logic [3*GRID_AXIS_BITS-1:0]         own_coords,
  input  logic [2:0]                          periodic_mask,
  input  logic [COORD_BITS-1:0]               halo_width,
  output logic                                out_valid,
  output logic signed [COORD_BITS+1:0]        out_wx,
  output logic signed [COORD_BITS+1:0]        out_wy,
  output logic signed [COORD_BITS+1:0]        out_wz,
  output logic [3*GRID_AXIS_BITS-1:0]         out_rank,
  output logic                                out_local,
  output logic                                out_halo
);
  import pdc_pkg::*;

  localparam int PB  = COORD_BITS + 2;
  localparam int QB  = GRID_AXIS_BITS + 1;
  localparam int AW  = 2 * PB + 1;
  localparam int IW  = 3 * AW + 1;
  localparam int GAB = GRID_AXIS_BITS;
  localparam int AXL = PB + 3 + QB;
  localparam int VL  = AXL + 2;
  localparam int TW  = 2 * GAB + 2;
  localparam int RW  = 3 * GAB;
  localparam int RXW = 3 * GAB + 3;

  logic signed [PB-1:0] w   [3];
  logic [GAB-1:0]       cel [3];
  pdc_flags_t           fl  [3];
  logic [QB-1:0]        g   [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    pdc_axis #(
      .COORD_BITS     (COORD_BITS),
      .GRID_AXIS_BITS (GRID_AXIS_BITS)
    ) u_axis (
      .clk       (clk),
      .in_p      ($signed(in_data[a*AW +: PB])),
      .in_mag    (in_data[a*AW + PB +: PB]),
      .in_neg    (in_data[a*AW + 2*PB]),
      .in_wf     (in_data[IW-1]),
      .gmin      (box_min[a*COORD_BITS +: COORD_BITS]),
      .gmax      (box_max[a*COORD_BITS +: COORD_BITS]),
      .lmin      (local_min[a*COORD_BITS +: COORD_BITS]),
      .lmax      (local_max[a*COORD_BITS +: COORD_BITS]),
      .gfield    (grid_shape[a*QB +: QB]),
      .own       (own_coords[a*GAB +: GAB]),
      .per       (periodic_mask[a]),
      .halo      (halo_width),
      .out_w     (w[a]),
      .out_cell  (cel[a]),
      .out_flags (fl[a]),
      .out_g     (g[a])
    );
  end

  logic [VL-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[VL-2:0], in_valid};
  end

  // R1: partial rank
  logic [TW-1:0]        t_nxt, t_r;
  logic [GAB-1:0]       cz_r;
  logic signed [PB-1:0] w1_r [3];
  logic                 loc1_r, wide1_r;
  // R2: final rank
  logic [RXW-1:0]       rx;
  logic [RW-1:0]        rank_r;
  logic signed [PB-1:0] w2_r [3];
  logic                 loc2_r, halo2_r;

  assign t_nxt = TW'(cel[0]) * TW'(g[1]) + TW'(cel[1]);
  assign rx    = RXW'(t_r) * RXW'(g[2]) + RXW'(cz_r);

  always_ff @(posedge clk) begin
    t_r     <= t_nxt;
    cz_r    <= cel[2];
    loc1_r  <= fl[0].in_local && fl[1].in_local && fl[2].in_local;
    wide1_r <= fl[0].in_wide && fl[1].in_wide && fl[2].in_wide;
    rank_r  <= rx[RW-1:0];
    loc2_r  <= loc1_r;
    halo2_r <= wide1_r && !loc1_r;
    for (int a = 0; a < 3; a++) begin
      w1_r[a] <= w[a];
      w2_r[a] <= w1_r[a];
    end
  end

  assign out_valid = vld_r[VL-1];
  assign out_wx    = w2_r[0];
  assign out_wy    = w2_r[1];
  assign out_wz    = w2_r[2];
  assign out_rank  = rank_r;
  assign out_local = loc2_r;
  assign out_halo  = halo2_r;

endmodule

// ----- rtl/core/particle_domain_classifier.sv -----
// Top level of the particle domain classifier: config registers and wiring.
// Depends on pdc_pkg, pdc_front, pdc_fifo, pdc_back.
//
// Usage:
//  - Requests: drive in_pos_x/y/z and in_wrap_first with start high; the
//    request is taken at an edge where start is high and busy is low.
//    One request per cycle is sustained.
//  - Results: out_valid pulses for one cycle with wrapped position, rank
//    and local/halo flags. Results keep request order.
//  - Path: a request passes the front-end register, the queue, the
//    one-bit-per-stage floor-mod pipeline, stages A, B and S, the cell
//    quotient stages and the rank registers R1 and R2 before its result.
//  - The receiver cannot stall; the back end never stops, so the queue
//    between front and back never fills and busy stays low in practice.
//  - Config: cfg_index/cfg_data written when cfg_valid is high; cfg_ready
//    is always high. Write only while no request is in flight.
//  - Reset (synchronous, rst_n low): pipeline and queue empty, registers
//    to a full global and local box, 1x1x1 grid, all axes periodic.
module particle_domain_classifier #(
  parameter int COORD_BITS     = pdc_pkg::COORD_BITS_DEF,
  parameter int GRID_AXIS_BITS = pdc_pkg::GRID_AXIS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS+1:0]  in_pos_x,
  input  logic signed [COORD_BITS+1:0]  in_pos_y,
  input  logic signed [COORD_BITS+1:0]  in_pos_z,
  input  logic                          in_wrap_first,
  output logic                          out_valid,
  output logic signed [COORD_BITS+1:0]  out_wrapped_x,
  output logic signed [COORD_BITS+1:0]  out_wrapped_y,
  output logic signed [COORD_BITS+1:0]  out_wrapped_z,
  output logic [3*GRID_AXIS_BITS-1:0]   out_target_rank,
  output logic                          out_inside_local,
  output logic                          out_inside_halo,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [3*COORD_BITS-1:0]       cfg_data
);
  import pdc_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int QB = GRID_AXIS_BITS + 1;
  localparam int IW = 3 * (2 * (CB + 2) + 1) + 1;

  logic [3*CB-1:0]             box_min_r, box_max_r, local_min_r, local_max_r;
  logic [3*QB-1:0]             grid_shape_r;
  logic [3*GRID_AXIS_BITS-1:0] own_coords_r;
  logic [2:0]                  periodic_mask_r;
  logic [CB-1:0]               halo_width_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_min_r       <= '0;
      box_max_r       <= '1;
      local_min_r     <= '0;
      local_max_r     <= '1;
      grid_shape_r    <= {3{{GRID_AXIS_BITS{1'b0}}, 1'b1}};
      own_coords_r    <= '0;
      periodic_mask_r <= 3'b111;
      halo_width_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BOX_MIN:       box_min_r       <= cfg_data;
        REG_BOX_MAX:       box_max_r       <= cfg_data;
        REG_LOCAL_MIN:     local_min_r     <= cfg_data;
        REG_LOCAL_MAX:     local_max_r     <= cfg_data;
        REG_GRID_SHAPE:    grid_shape_r    <= cfg_data[3*QB-1:0];
        REG_OWN_COORDS:    own_coords_r    <= cfg_data[3*GRID_AXIS_BITS-1:0];
        REG_PERIODIC_MASK: periodic_mask_r <= cfg_data[2:0];
        REG_HALO_WIDTH:    halo_width_r    <= cfg_data[CB-1:0];
        default: ;
      endcase
    end
  end

  // front -> queue -> back
  logic          fifo_full, push, pop_valid;
  logic [IW-1:0] push_data, pop_data;

  pdc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .pos_x      (in_pos_x),
    .pos_y      (in_pos_y),
    .pos_z      (in_pos_z),
    .wrap_first (in_wrap_first),
    .box_min    (box_min_r),
    .fifo_full  (fifo_full),
    .push       (push),
    .push_data  (push_data)
  );

  pdc_fifo #(.WIDTH(IW)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop_valid (pop_valid),
    .pop_data  (pop_data)
  );

  pdc_back #(
    .COORD_BITS     (COORD_BITS),
    .GRID_AXIS_BITS (GRID_AXIS_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (pop_valid),
    .in_data       (pop_data),
    .box_min       (box_min_r),
    .box_max       (box_max_r),
    .local_min     (local_min_r),
    .local_max     (local_max_r),
    .grid_shape    (grid_shape_r),
    .own_coords    (own_coords_r),
    .periodic_mask (periodic_mask_r),
    .halo_width    (halo_width_r),
    .out_valid     (out_valid),
    .out_wx        (out_wrapped_x),
    .out_wy        (out_wrapped_y),
    .out_wz        (out_wrapped_z),
    .out_rank      (out_target_rank),
    .out_local     (out_inside_local),
    .out_halo      (out_inside_halo)
  );

endmodule

// ----- tb/particle_domain_classifier_test.sv -----
// Self-checking testbench for the particle domain classifier.
// Depends on pdc_pkg and the particle_domain_classifier RTL only.
`timescale 1ns / 1ps

module particle_domain_classifier_test;
  import pdc_pkg::*;

  localparam int CB   = 20;
  localparam int GB   = 4;
  localparam int PB   = CB + 2;
  localparam int LATENCY = CB + GB + 10;

  typedef struct packed {
    logic signed [PB-1:0] x;
    logic signed [PB-1:0] y;
    logic signed [PB-1:0] z;
    logic                 wrap_first;
  } request_t;

  typedef struct packed {
    logic signed [PB-1:0] wx;
    logic signed [PB-1:0] wy;
    logic signed [PB-1:0] wz;
    logic [3*GB-1:0]      rank;
    logic                 in_local;
    logic                 in_halo;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [PB-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic in_wrap_first = 1'b0;
  logic out_valid;
  logic signed [PB-1:0] out_wrapped_x, out_wrapped_y, out_wrapped_z;
  logic [3*GB-1:0] out_target_rank;
  logic out_inside_local, out_inside_halo;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = REG_BOX_MIN;
  logic [3*CB-1:0] cfg_data = '0;

  particle_domain_classifier dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the configuration registers
  logic [3*CB-1:0] s_box_min, s_box_max, s_loc_min, s_loc_max;
  logic [14:0] s_grid;
  logic [11:0] s_own;
  logic [2:0]  s_per;
  logic [CB-1:0] s_halo;

  request_t pending_requests[$];
  verdict_t expected_verdicts[$];
  int mismatches = 0;
  bit stimulus_done = 1'b0;

  function automatic void add_request(request_t r);
    pending_requests.insert(pending_requests.size(), r);
  endfunction

  function automatic longint grid_size(int a);
    longint g;
    g = s_grid[a*5 +: 5];
    if (g < 1) g = 1;
    if (g > 16) g = 16;
    return g;
  endfunction

  // predicted classification of one request under the shadow registers
  function automatic verdict_t classify(request_t r);
    verdict_t v;
    longint p, gmin, gmax, lmin, lmax, len, g, own, w, q, lo, hi, c, rm, rank;
    longint axis_cell[3];
    logic signed [PB-1:0] pos[3];
    bit per, loc, wide;
    loc = 1; wide = 1;
    pos[0] = r.x; pos[1] = r.y; pos[2] = r.z;
    for (int a = 0; a < 3; a++) begin
      p    = pos[a];
      gmin = s_box_min[a*CB +: CB];
      gmax = s_box_max[a*CB +: CB];
      lmin = s_loc_min[a*CB +: CB];
      lmax = s_loc_max[a*CB +: CB];
      len  = gmax - gmin;
      g    = grid_size(a);
      own  = s_own[a*GB +: GB];
      per  = s_per[a];
      w = p;
      if (per && len > 0) begin
        rm = (p - gmin) % len;
        if (rm < 0) rm += len;
        w = gmin + rm;
      end
      if (a == 0) v.wx = w[PB-1:0];
      else if (a == 1) v.wy = w[PB-1:0];
      else v.wz = w[PB-1:0];
      q = r.wrap_first ? w : p;
      if (len > 0 && q > gmin) begin
        c = ((q - gmin) * g) / len;
        axis_cell[a] = (c > g - 1) ? g - 1 : c;
      end else axis_cell[a] = 0;
      if (q < lmin || q >= lmax) loc = 0;
      lo = (per || own > 0) ? lmin - s_halo : lmin;
      hi = (per || own + 1 < g) ? lmax + s_halo : lmax;
      if (q < lo || q >= hi) wide = 0;
    end
    rank = (axis_cell[0] * grid_size(1) + axis_cell[1]) * grid_size(2) + axis_cell[2];
    v.rank = rank[3*GB-1:0];
    v.in_local = loc;
    v.in_halo = wide && !loc;
    return v;
  endfunction

  // driver: one request per handshake, random gaps between requests
  int gap = 0;
  bit req_taken = 1'b0;
  always @(negedge clk) begin
    if (rst_n && (!start || req_taken)) begin
      if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (pending_requests.size() > 0 && !cfg_valid) begin
        request_t r;
        r = pending_requests.pop_front();
        in_pos_x <= r.x; in_pos_y <= r.y; in_pos_z <= r.z;
        in_wrap_first <= r.wrap_first;
        start <= 1'b1;
        case ($urandom_range(0, 19))
          0: gap <= $urandom_range(5, 40);
          1, 2, 3, 4: gap <= $urandom_range(1, 3);
          default: gap <= 0;
        endcase
      end else start <= 1'b0;
    end
  end

  // expectation is formed at the accepting edge
  always @(posedge clk) begin
    req_taken <= rst_n && start && !busy;
    if (rst_n && start && !busy)
      expected_verdicts.insert(expected_verdicts.size(),
        classify('{in_pos_x, in_pos_y, in_pos_z, in_wrap_first}));
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      verdict_t got, exp_v;
      got = '{out_wrapped_x, out_wrapped_y, out_wrapped_z, out_target_rank,
              out_inside_local, out_inside_halo};
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        exp_v = expected_verdicts.pop_front();
        if (got !== exp_v) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp w=%0d,%0d,%0d rank=%0d loc=%b halo=%b",
                      " | got w=%0d,%0d,%0d rank=%0d loc=%b halo=%b"},
              exp_v.wx, exp_v.wy, exp_v.wz, exp_v.rank, exp_v.in_local,
              exp_v.in_halo, got.wx, got.wy, got.wz, got.rank, got.in_local,
              got.in_halo);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_requests.size() > 0 || start || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [3*CB-1:0] val);
    @(negedge clk);
    cfg_index <= idx; cfg_data <= val; cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_BOX_MIN:       s_box_min = val;
      REG_BOX_MAX:       s_box_max = val;
      REG_LOCAL_MIN:     s_loc_min = val;
      REG_LOCAL_MAX:     s_loc_max = val;
      REG_GRID_SHAPE:    s_grid = val[14:0];
      REG_OWN_COORDS:    s_own = val[11:0];
      REG_PERIODIC_MASK: s_per = val[2:0];
      default:           s_halo = val[CB-1:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [3*CB-1:0] pack3(int x, int y, int z);
    return {z[CB-1:0], y[CB-1:0], x[CB-1:0]};
  endfunction

  function automatic logic signed [PB-1:0] rand_pos(int lo_v, int hi_v);
    int v;
    case ($urandom_range(0, 9))
      0: v = $urandom;
      1: v = -(1 << (PB - 1));
      2: v = (1 << (PB - 1)) - 1;
      default: v = lo_v + $signed($urandom_range(0, hi_v - lo_v));
    endcase
    return v[PB-1:0];
  endfunction

  // a random but mostly sensible decomposition
  task automatic random_setting();
    int bmin[3], bmax[3], g[3], own[3], lmin[3], lmax[3];
    for (int a = 0; a < 3; a++) begin
      bmin[a] = $urandom_range(0, 200000);
      bmax[a] = bmin[a] + $urandom_range(1, 800000);
      g[a] = $urandom_range(1, 16);
      own[a] = $urandom_range(0, g[a] - 1);
      lmin[a] = bmin[a] + (bmax[a] - bmin[a]) / g[a] * own[a];
      lmax[a] = lmin[a] + (bmax[a] - bmin[a]) / g[a];
      if ($urandom_range(0, 15) == 0) bmax[a] = bmin[a] - $urandom_range(0, 5); // empty axis
    end
    write_reg(REG_BOX_MIN, pack3(bmin[0], bmin[1], bmin[2]));
    write_reg(REG_BOX_MAX, pack3(bmax[0], bmax[1], bmax[2]));
    write_reg(REG_LOCAL_MIN, pack3(lmin[0], lmin[1], lmin[2]));
    write_reg(REG_LOCAL_MAX, pack3(lmax[0], lmax[1], lmax[2]));
    write_reg(REG_GRID_SHAPE, {g[2][4:0], g[1][4:0], g[0][4:0]});
    write_reg(REG_OWN_COORDS, {own[2][3:0], own[1][3:0], own[0][3:0]});
    write_reg(REG_PERIODIC_MASK, $urandom_range(0, 7));
    write_reg(REG_HALO_WIDTH, $urandom_range(0, 20) == 0 ? $urandom : $urandom_range(0, 30000));
  endtask

  task automatic random_batch(int n);
    request_t r;
    int lo_v, hi_v;
    lo_v = int'(s_box_min[CB-1:0]) - 300000;
    hi_v = int'(s_box_max[CB-1:0]) + 300000;
    for (int i = 0; i < n; i++) begin
      r.x = rand_pos(lo_v, hi_v);
      r.y = rand_pos(int'(s_box_min[CB +: CB]) - 300000, int'(s_box_max[CB +: CB]) + 300000);
      r.z = rand_pos(int'(s_box_min[2*CB +: CB]) - 300000,
                     int'(s_box_max[2*CB +: CB]) + 300000);
      r.wrap_first = $urandom_range(0, 1);
      add_request(r);
    end
  endtask

  initial begin
    s_box_min = '0; s_box_max = '1; s_loc_min = '0; s_loc_max = '1;
    s_grid = {5'd1, 5'd1, 5'd1}; s_own = '0; s_per = 3'd7; s_halo = '0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: reset setting, field extremes
    add_request('{22'sh200000, 22'sh1fffff, 22'sd0, 1'b1});
    add_request('{22'sh1fffff, 22'sh200000, -22'sd1, 1'b0});
    add_request('{22'sh0fffff, 22'sh100000, 22'sh3fffff, 1'b1});
    wait_drained();

    // directed: extreme register values, saturated grid, own coords at their maximum
    write_reg(REG_BOX_MIN, '1);
    write_reg(REG_BOX_MAX, '0);              // inverted box on every axis
    write_reg(REG_LOCAL_MIN, pack3(100, 100, 100));
    write_reg(REG_LOCAL_MAX, pack3(50, 50, 50)); // empty local box
    write_reg(REG_GRID_SHAPE, '1);            // 31 per axis, saturates
    write_reg(REG_OWN_COORDS, '1);
    write_reg(REG_PERIODIC_MASK, 3'd0);
    write_reg(REG_HALO_WIDTH, {CB{1'b1}});
    add_request('{22'sd75, 22'sd0, -22'sd5, 1'b1});
    add_request('{22'sh1fffff, 22'sh200000, 22'sd120, 1'b0});
    wait_drained();

    // directed: small box periodic in x and z, halo on neighbour sides only, grid size zero in y
    write_reg(REG_BOX_MIN, pack3(1000, 0, 1000));
    write_reg(REG_BOX_MAX, pack3(2000, 16, 1001));
    write_reg(REG_LOCAL_MIN, pack3(1000, 0, 1000));
    write_reg(REG_LOCAL_MAX, pack3(1250, 8, 1001));
    write_reg(REG_GRID_SHAPE, {5'd1, 5'd0, 5'd4});
    write_reg(REG_OWN_COORDS, {4'd0, 4'd0, 4'd0});
    write_reg(REG_PERIODIC_MASK, 3'b101);
    write_reg(REG_HALO_WIDTH, 20);
    add_request('{22'sd999, 22'sd3, 22'sd1000, 1'b1});
    add_request('{22'sd2000, -22'sd1, 22'sd1001, 1'b1});
    add_request('{22'sd1260, 22'sd8, 22'sd999, 1'b1});
    add_request('{22'sd980, 22'sd16, 22'sd5000, 1'b0});
    add_request('{-22'sd3000, 22'sd20, -22'sd7, 1'b1});
    add_request('{22'sd1999, 22'sd15, 22'sd1000, 1'b0});
    wait_drained();

    // random phases, each under a fresh setting
    for (int ph = 0; ph < 9; ph++) begin
      random_setting();
      random_batch(150);
      wait_drained();
    end
    stimulus_done = 1'b1;

    if (mismatches == 0)
      $display("particle_domain_classifier regression: pass");
    else
      $display("particle_domain_classifier regression: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("particle_domain_classifier regression: fail");
    $finish;
  end

endmodule
